>>> src/cta_pkg.sv
package cta_pkg;

  // Request operations
  typedef enum logic [2:0] {
    MODE_LD_WEIGHT = 3'd0,
    MODE_LD_INPUT  = 3'd1,
    MODE_LD_OUTPUT = 3'd2,
    MODE_RUN       = 3'd3,
    MODE_READ      = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_CHAN  = 2'd2
  } status_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_INPUT_SIZE  = 3'd0,
    REG_INPUT_DEPTH = 3'd1,
    REG_ROW_START   = 3'd2,
    REG_ROW_END     = 3'd3,
    REG_COL_START   = 3'd4,
    REG_COL_END     = 3'd5,
    REG_OC_START    = 3'd6,
    REG_OC_END      = 3'd7
  } reg_idx_e;

  localparam int KSIZE = 3;
  // width of internal store index arithmetic
  localparam int IDX_W = 20;

  localparam logic [4:0] RST_INPUT_SIZE  = 5'd16;
  localparam logic [3:0] RST_INPUT_DEPTH = 4'd8;
  localparam logic [4:0] RST_ROW_START   = 5'd0;
  localparam logic [4:0] RST_ROW_END     = 5'd16;
  localparam logic [4:0] RST_COL_START   = 5'd0;
  localparam logic [4:0] RST_COL_END     = 5'd16;
  localparam logic [3:0] RST_OC_START    = 4'd0;
  localparam logic [3:0] RST_OC_END      = 4'd8;

  typedef logic [2:0]  mode_t;
  typedef logic [10:0] index_t;
  typedef logic [3:0]  chan_t;
  typedef logic [1:0]  status_t;

  // MAC unit control
  typedef struct packed {
    logic load;
    logic mul;
    logic add;
  } mac_op_t;

endpackage

>>> src/cta_if.sv
interface cta_req_if;
  logic                  valid;
  logic                  ready;
  cta_pkg::mode_t        mode;
  cta_pkg::index_t       index;
  logic signed [31:0]    value;
  cta_pkg::chan_t        in_chan_low;
  cta_pkg::chan_t        in_chan_high;
  modport source (output valid, mode, index, value, in_chan_low, in_chan_high,
                  input ready);
  modport sink (input valid, mode, index, value, in_chan_low, in_chan_high,
                output ready);
endinterface

interface cta_rsp_if;
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    read_data;
  cta_pkg::status_t      status;
  modport source (output valid, read_data, status, input ready);
  modport sink (input valid, read_data, status, output ready);
endinterface

interface cta_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/cta_ram.sv
module cta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/cta_mac.sv
module cta_mac (
  input  logic             clk_i,
  input  cta_pkg::mac_op_t op_i,
  input  logic [31:0]      a_i,
  input  logic [31:0]      b_i,
  input  logic [31:0]      load_i,
  output logic [31:0]      acc_o
);

  import cta_pkg::*;

  logic [31:0] prod_q;
  logic [31:0] acc_q;

  // product registered before the wrap-around add
  always_ff @(posedge clk_i) begin
    if (op_i.mul) begin
      prod_q <= a_i * b_i;
    end
    if (op_i.load) begin
      acc_q <= load_i;
    end else if (op_i.add) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign acc_o = acc_q;

endmodule

>>> src/conv3x3_tile_accumulator.sv
// 3x3 multichannel convolution accumulator over a tile of the output map.
// Channels: req_i (sink) takes requests: load weight, load input, load output
// word, run, read output word. rsp_o (source) gives exactly one answer per
// request: read_data and status. cfg_i writes the eight window and size
// registers; it is always ready and should only be used while idle.
// A load answers after its dispatch and finish steps, a read after dispatch,
// read-data and finish; a new request is taken once the block is back in idle.
// A run walks output channel, row, column, input channel and kernel tap with
// one shared multiply-accumulate unit and single-port reads of the stores:
// each output position is read, loaded into the accumulator and written back,
// each input channel sets its store bases, a tap inside the map has address,
// wait and accumulate steps and a tap in the padding is skipped at its address.
// Reset: config registers take their defaults and the output store is swept
// to zero, one word a cycle, over all MAX_OUT_CHANNELS*OUT_TILE*OUT_TILE words
// (2048 by default); no request is taken during the sweep.
// Stall: a finished answer sits in the output register; the sequencer waits
// in its finish step until that register is free.
module conv3x3_tile_accumulator #(
  parameter int MAX_IN_SIZE      = 16,
  parameter int MAX_IN_CHANNELS  = 8,
  parameter int MAX_OUT_CHANNELS = 8,
  parameter int OUT_TILE         = 16,
  parameter int CONV_STRIDE      = 1,
  parameter int CONV_PAD         = 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cta_req_if.sink   req_i,
  cta_rsp_if.source rsp_o,
  cta_cfg_if.sink   cfg_i
);

  import cta_pkg::*;

  localparam int W_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * KSIZE * KSIZE;
  localparam int I_DEPTH = MAX_IN_CHANNELS * MAX_IN_SIZE * MAX_IN_SIZE;
  localparam int O_DEPTH = MAX_OUT_CHANNELS * OUT_TILE * OUT_TILE;
  localparam int WAW = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int IAW = (I_DEPTH > 1) ? $clog2(I_DEPTH) : 1;
  localparam int OAW = (O_DEPTH > 1) ? $clog2(O_DEPTH) : 1;
  localparam logic [1:0] KLAST = 2'(KSIZE - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_RD_DATA, S_POS_RD, S_POS_WAIT,
    S_IC_SET, S_TAP_ADDR, S_TAP_WAIT, S_TAP_ACC, S_POS_WR, S_FINISH
  } state_e;

  state_e state_q;

  // configuration
  logic [4:0] in_size_q, row_start_q, row_end_q, col_start_q, col_end_q;
  logic [3:0] in_depth_q, oc_start_q, oc_end_q;

  // latched request
  logic [2:0]  mode_q;
  logic [10:0] idx_q;
  logic [31:0] value_q;
  logic [3:0]  ic_lo_q, ic_hi_q;

  // loop counters
  logic [3:0] oc_q, ic_q;
  logic [4:0] r_q, c_q;
  logic [1:0] kr_q, kc_q;

  logic [IDX_W-1:0] oi_q, w_base_q, i_base_q;
  logic             o_ok_q, beyond_q;
  logic [31:0]      res_rdata_q;
  logic [1:0]       res_status_q;
  logic             out_valid_q;
  logic [31:0]      out_rdata_q;
  logic [1:0]       out_status_q;
  logic [OAW-1:0]   clr_cnt_q;

  // store ports
  logic           w_we, w_re, i_we, i_re, o_we, o_re;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [IAW-1:0] i_waddr, i_raddr;
  logic [OAW-1:0] o_waddr, o_raddr;
  logic [31:0]    o_wdata, w_rdata, i_rdata, o_rdata, acc;
  mac_op_t        mac_op;

  // ---------------------------------------------------------------
  // Index arithmetic
  // ---------------------------------------------------------------
  logic [IDX_W-1:0] idx20, oi_c, wi_c, ii_c;
  logic             o_ok_c, idx_w_ok, idx_i_ok, idx_o_ok;
  logic [7:0]       row_t, col_t, pr, pc;
  logic             row_in, col_in, tap_live, tap_ok;

  assign idx20    = IDX_W'(idx_q);
  assign idx_w_ok = idx20 < IDX_W'(W_DEPTH);
  assign idx_i_ok = idx20 < IDX_W'(I_DEPTH);
  assign idx_o_ok = idx20 < IDX_W'(O_DEPTH);

  assign oi_c   = (IDX_W'(oc_q) * IDX_W'(OUT_TILE) + IDX_W'(r_q)) * IDX_W'(OUT_TILE)
                + IDX_W'(c_q);
  assign o_ok_c = (IDX_W'(r_q) < IDX_W'(OUT_TILE)) && (IDX_W'(c_q) < IDX_W'(OUT_TILE))
               && (oi_c < IDX_W'(O_DEPTH));

  // padding test on the tap position in the input map
  assign row_t  = 8'(CONV_STRIDE) * 8'(r_q) + 8'(kr_q);
  assign col_t  = 8'(CONV_STRIDE) * 8'(c_q) + 8'(kc_q);
  assign pr     = row_t - 8'(CONV_PAD);
  assign pc     = col_t - 8'(CONV_PAD);
  assign row_in = (row_t >= 8'(CONV_PAD)) && (pr < 8'(in_size_q));
  assign col_in = (col_t >= 8'(CONV_PAD)) && (pc < 8'(in_size_q));
  assign tap_live = row_in && col_in;

  assign wi_c   = w_base_q + IDX_W'(kr_q) * IDX_W'(KSIZE) + IDX_W'(kc_q);
  assign ii_c   = (i_base_q + IDX_W'(pr)) * IDX_W'(in_size_q) + IDX_W'(pc);
  assign tap_ok = o_ok_q && (wi_c < IDX_W'(W_DEPTH)) && (ii_c < IDX_W'(I_DEPTH));

  // tap step: kc, then kr, then input channel
  logic [1:0] kc_n, kr_n;
  logic [3:0] ic_n;
  state_e     tap_next;

  always_comb begin
    kc_n     = kc_q + 2'd1;
    kr_n     = kr_q;
    ic_n     = ic_q;
    tap_next = S_TAP_ADDR;
    if (kc_q == KLAST) begin
      kc_n = 2'd0;
      kr_n = kr_q + 2'd1;
      if (kr_q == KLAST) begin
        kr_n = 2'd0;
        ic_n = ic_q + 4'd1;
        tap_next = (ic_q + 4'd1 == ic_hi_q) ? S_POS_WR : S_IC_SET;
      end
    end
  end

  // position step: column, then row, then output channel
  logic [3:0] oc_n;
  logic [4:0] r_n, c_n;
  logic       pos_done;

  always_comb begin
    c_n      = c_q + 5'd1;
    r_n      = r_q;
    oc_n     = oc_q;
    pos_done = 1'b0;
    if (c_q + 5'd1 == col_end_q) begin
      c_n = col_start_q;
      r_n = r_q + 5'd1;
      if (r_q + 5'd1 == row_end_q) begin
        r_n  = row_start_q;
        oc_n = oc_q + 4'd1;
        pos_done = (oc_q + 4'd1 == oc_end_q);
      end
    end
  end

  // ---------------------------------------------------------------
  // Store port muxing
  // ---------------------------------------------------------------
  always_comb begin
    w_we = 1'b0; i_we = 1'b0; o_we = 1'b0;
    w_re = 1'b0; i_re = 1'b0; o_re = 1'b0;
    w_waddr = idx20[WAW-1:0];
    i_waddr = idx20[IAW-1:0];
    o_waddr = idx20[OAW-1:0];
    o_wdata = value_q;
    w_raddr = wi_c[WAW-1:0];
    i_raddr = ii_c[IAW-1:0];
    o_raddr = idx20[OAW-1:0];
    mac_op  = '0;
    case (state_q)
      S_CLEAR: begin
        o_we    = 1'b1;
        o_waddr = clr_cnt_q;
        o_wdata = '0;
      end
      S_DISPATCH: begin
        case (mode_q)
          MODE_LD_WEIGHT: w_we = idx_w_ok;
          MODE_LD_INPUT:  i_we = idx_i_ok;
          MODE_LD_OUTPUT: o_we = idx_o_ok;
          MODE_READ:      o_re = idx_o_ok;
          default: ;
        endcase
      end
      S_POS_RD: begin
        o_re    = o_ok_c;
        o_raddr = oi_c[OAW-1:0];
      end
      S_POS_WAIT: mac_op.load = 1'b1;
      S_TAP_ADDR: begin
        w_re = tap_live && tap_ok;
        i_re = tap_live && tap_ok;
      end
      S_TAP_WAIT: mac_op.mul = 1'b1;
      S_TAP_ACC:  mac_op.add = 1'b1;
      S_POS_WR: begin
        o_we    = o_ok_q;
        o_waddr = oi_q[OAW-1:0];
        o_wdata = acc;
      end
      default: ;
    endcase
  end

  cta_ram #(.WIDTH(32), .DEPTH(W_DEPTH)) u_w_ram (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(value_q),
    .re_i(w_re), .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  cta_ram #(.WIDTH(32), .DEPTH(I_DEPTH)) u_i_ram (
    .clk_i, .we_i(i_we), .waddr_i(i_waddr), .wdata_i(value_q),
    .re_i(i_re), .raddr_i(i_raddr), .rdata_o(i_rdata)
  );

  cta_ram #(.WIDTH(32), .DEPTH(O_DEPTH)) u_o_ram (
    .clk_i, .we_i(o_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .re_i(o_re), .raddr_i(o_raddr), .rdata_o(o_rdata)
  );

  // unread output words (out of tile) start the sum at zero
  cta_mac u_mac (
    .clk_i, .op_i(mac_op), .a_i(w_rdata), .b_i(i_rdata),
    .load_i(o_ok_q ? o_rdata : 32'd0), .acc_o(acc)
  );

  // ---------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_size_q   <= RST_INPUT_SIZE;
      in_depth_q  <= RST_INPUT_DEPTH;
      row_start_q <= RST_ROW_START;
      row_end_q   <= RST_ROW_END;
      col_start_q <= RST_COL_START;
      col_end_q   <= RST_COL_END;
      oc_start_q  <= RST_OC_START;
      oc_end_q    <= RST_OC_END;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_INPUT_SIZE:  in_size_q   <= cfg_i.data[4:0];
        REG_INPUT_DEPTH: in_depth_q  <= cfg_i.data[3:0];
        REG_ROW_START:   row_start_q <= cfg_i.data[4:0];
        REG_ROW_END:     row_end_q   <= cfg_i.data[4:0];
        REG_COL_START:   col_start_q <= cfg_i.data[4:0];
        REG_COL_END:     col_end_q   <= cfg_i.data[4:0];
        REG_OC_START:    oc_start_q  <= cfg_i.data[3:0];
        REG_OC_END:      oc_end_q    <= cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_rdata_q;
  assign rsp_o.status    = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // the finish step owns the output register while it is in that step
      if (rsp_o.ready && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + OAW'(1);
          if (clr_cnt_q == OAW'(O_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_i.valid) begin
            mode_q       <= req_i.mode;
            idx_q        <= req_i.index;
            value_q      <= req_i.value;
            ic_lo_q      <= req_i.in_chan_low;
            ic_hi_q      <= req_i.in_chan_high;
            res_rdata_q  <= '0;
            res_status_q <= ST_OK;
            beyond_q     <= 1'b0;
            state_q      <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state_q <= S_FINISH;
          case (mode_q)
            MODE_LD_WEIGHT: if (!idx_w_ok) res_status_q <= ST_RANGE;
            MODE_LD_INPUT:  if (!idx_i_ok) res_status_q <= ST_RANGE;
            MODE_LD_OUTPUT: if (!idx_o_ok) res_status_q <= ST_RANGE;
            MODE_READ: begin
              if (idx_o_ok) state_q <= S_RD_DATA;
              else res_status_q <= ST_RANGE;
            end
            MODE_RUN: begin
              oc_q <= oc_start_q;
              r_q  <= row_start_q;
              c_q  <= col_start_q;
              if (ic_hi_q > in_depth_q) begin
                res_status_q <= ST_CHAN;
              end else if (oc_start_q < oc_end_q && row_start_q < row_end_q &&
                           col_start_q < col_end_q) begin
                state_q <= S_POS_RD;
              end
            end
            default: ;
          endcase
        end
        S_RD_DATA: begin
          res_rdata_q <= o_rdata;
          state_q     <= S_FINISH;
        end
        S_POS_RD: begin
          oi_q    <= oi_c;
          o_ok_q  <= o_ok_c;
          ic_q    <= ic_lo_q;
          kr_q    <= 2'd0;
          kc_q    <= 2'd0;
          state_q <= S_POS_WAIT;
        end
        S_POS_WAIT: begin
          state_q <= (ic_lo_q < ic_hi_q) ? S_IC_SET : S_POS_WR;
        end
        S_IC_SET: begin
          w_base_q <= (IDX_W'(oc_q) * IDX_W'(in_depth_q) + IDX_W'(ic_q))
                    * IDX_W'(KSIZE * KSIZE);
          i_base_q <= IDX_W'(ic_q) * IDX_W'(in_size_q);
          state_q  <= S_TAP_ADDR;
        end
        S_TAP_ADDR: begin
          if (tap_live && tap_ok) begin
            state_q <= S_TAP_WAIT;
          end else begin
            // tap outside a store: skipped and flagged; padding: skipped
            if (tap_live) beyond_q <= 1'b1;
            kc_q    <= kc_n;
            kr_q    <= kr_n;
            ic_q    <= ic_n;
            state_q <= tap_next;
          end
        end
        S_TAP_WAIT: state_q <= S_TAP_ACC;
        S_TAP_ACC: begin
          kc_q    <= kc_n;
          kr_q    <= kr_n;
          ic_q    <= ic_n;
          state_q <= tap_next;
        end
        S_POS_WR: begin
          c_q  <= c_n;
          r_q  <= r_n;
          oc_q <= oc_n;
          if (pos_done) begin
            if (beyond_q) res_status_q <= ST_RANGE;
            state_q <= S_FINISH;
          end else begin
            state_q <= S_POS_RD;
          end
        end
        S_FINISH: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_rdata_q  <= res_rdata_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/cta_checker.sv
module cta_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [31:0]            rsp_read_data,
  input cta_pkg::status_t       rsp_status
);

  import cta_pkg::*;

  // a held answer does not change
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                && $stable(rsp_status))
    else $error("answer changed while stalled");

  // failed requests never return data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status != ST_OK |-> rsp_read_data == 32'd0)
    else $error("data returned with error status");

  // one request in flight at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

endmodule

bind conv3x3_tile_accumulator cta_checker u_cta_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid     (req_i.valid),
  .req_ready     (req_i.ready),
  .rsp_valid     (rsp_o.valid),
  .rsp_ready     (rsp_o.ready),
  .rsp_read_data (rsp_o.read_data),
  .rsp_status    (rsp_o.status)
);
